FILE: rtl/core/rdst_pkg.sv
// ----------------------------------------------------------------------------
// Range distinct-symbol tree package
// Shared widths, request codes and the node update control type.
// ----------------------------------------------------------------------------
package rdst_pkg;

  localparam int unsigned LEAVES_DEF   = 1024;
  localparam int unsigned ALPHABET_DEF = 26;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned SYM_W        = 5;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned RANGE_W      = 11;
  localparam int unsigned MASK_W       = 26;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] REQ_ADD      = 2'd0;
  localparam logic [1:0] REQ_REPLACE  = 2'd1;
  localparam logic [1:0] REQ_QUERY    = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  typedef struct packed {
    logic [SYM_W-1:0] old_sym;
    logic [SYM_W-1:0] new_sym;
    logic             dec_en;
  } upd_t;

endpackage

FILE: rtl/core/rdst_node_alu.sv
// ----------------------------------------------------------------------------
// Node count update
// Counts one symbol down (when dec_en is set) and another up across a node
// word, saturating at both ends, and forms the presence mask of the input word.
// ----------------------------------------------------------------------------
module rdst_node_alu #(
  parameter int unsigned ALPHABET = rdst_pkg::ALPHABET_DEF
) (
  input  logic [ALPHABET*rdst_pkg::COUNT_W-1:0] word_i,
  input  rdst_pkg::upd_t                        upd_i,
  output logic [ALPHABET*rdst_pkg::COUNT_W-1:0] word_o,
  output logic [rdst_pkg::MASK_W-1:0]           mask_o
);
  import rdst_pkg::*;

  for (genvar s = 0; s < ALPHABET; s++) begin : g_lane
    logic [COUNT_W-1:0] c, cd;
    always_comb begin
      c  = word_i[s*COUNT_W +: COUNT_W];
      cd = c;
      if (upd_i.dec_en && (32'(upd_i.old_sym) == s) && (cd != '0)) begin
        cd = cd - COUNT_W'(1);
      end
      if ((32'(upd_i.new_sym) == s) && (cd != COUNT_MAX)) begin
        cd = cd + COUNT_W'(1);
      end
      word_o[s*COUNT_W +: COUNT_W] = cd;
    end
  end

  for (genvar s = 0; s < MASK_W; s++) begin : g_mask
    if (s < ALPHABET) begin : g_on
      assign mask_o[s] = |word_i[s*COUNT_W +: COUNT_W];
    end else begin : g_off
      assign mask_o[s] = 1'b0;
    end
  end

endmodule

FILE: rtl/core/range_distinct_symbol_tree.sv
// ----------------------------------------------------------------------------
// Range distinct-symbol tree
// Segment tree of per-symbol counts held in one node memory.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid_i / in_stall_o); a query
// returns its presence mask on the output channel (out_valid_o /
// out_stall_i). Add and replace return nothing.
// After reset the node memory is cleared one node a cycle, every node in
// turn, while in_stall_o is held high.
// An add does a read-modify-write of one node per level, leaf to root,
// through the single memory port (ST_URD then ST_UWR).
// A replace first takes the old leaf symbol in ST_LEAF and counts it down.
// A query walks the tree level by level, and each visited node is one
// memory read.
// One request is in work at a time. A finished mask waits in the output
// register while the receiver stalls; a further request may be taken then,
// and a second query holds at its end until the register is free.
// ----------------------------------------------------------------------------
module range_distinct_symbol_tree #(
  parameter int unsigned LEAVES   = rdst_pkg::LEAVES_DEF,
  parameter int unsigned ALPHABET = rdst_pkg::ALPHABET_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [rdst_pkg::POS_W-1:0]    position_i,
  input  logic [rdst_pkg::SYM_W-1:0]    symbol_i,
  input  logic [rdst_pkg::RANGE_W-1:0]  range_lo_i,
  input  logic [rdst_pkg::RANGE_W-1:0]  range_hi_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rdst_pkg::MASK_W-1:0]   present_mask_o
);
  import rdst_pkg::*;

  localparam int unsigned LW  = $clog2(LEAVES);
  localparam int unsigned NAW = LW + 1;
  localparam int unsigned IW  = NAW + 1;
  localparam int unsigned WW  = ALPHABET * COUNT_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LEAF, ST_URD, ST_UWR,
    ST_QTOP, ST_QA, ST_QAW, ST_QB, ST_QBW, ST_QSH
  } state_e;

  state_e            state_q;
  logic [NAW-1:0]    clr_q, node_q;
  logic [IW-1:0]     a_q, b_q, b_dec;
  logic [SYM_W-1:0]  sym_q, old_q;
  logic              rep_q;
  logic [MASK_W-1:0] acc_q, mask_q;
  logic              out_valid_q;

  logic [WW-1:0]     node_mem [2**NAW];
  logic [SYM_W-1:0]  leaf_mem [2**LW];
  logic [WW-1:0]     rd_q;
  logic [SYM_W-1:0]  leaf_rd_q;

  logic              mem_we, mem_re;
  logic [NAW-1:0]    mem_waddr, mem_raddr;
  logic [WW-1:0]     mem_wdata, alu_word;
  logic [MASK_W-1:0] alu_mask;
  upd_t              upd;

  logic              accept, upd_ok, out_free, out_set;
  logic [31:0]       hi_c;
  logic [LW-1:0]     leaf_addr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign upd_ok     = (32'(position_i) < LEAVES) && (32'(symbol_i) < ALPHABET);
  assign hi_c       = (32'(range_hi_i) > LEAVES) ? LEAVES : 32'(range_hi_i);
  assign leaf_addr  = LW'(position_i);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_set    = (state_q == ST_QTOP) && !(a_q < b_q) && out_free;
  assign b_dec      = b_q - IW'(1);

  assign upd.old_sym = old_q;
  assign upd.new_sym = sym_q;
  assign upd.dec_en  = rep_q;

  rdst_node_alu #(
    .ALPHABET(ALPHABET)
  ) u_alu (
    .word_i(rd_q),
    .upd_i (upd),
    .word_o(alu_word),
    .mask_o(alu_mask)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_q;
    mem_wdata = alu_word;
    mem_re    = 1'b0;
    mem_raddr = node_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_URD: mem_re = 1'b1;
      ST_UWR: mem_we = 1'b1;
      ST_QA: begin
        mem_re    = a_q[0];
        mem_raddr = a_q[NAW-1:0];
      end
      ST_QB: begin
        mem_re    = b_q[0];
        mem_raddr = b_dec[NAW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= node_mem[mem_raddr];
    end
    if (accept && upd_ok && (req_type_i == REQ_ADD || req_type_i == REQ_REPLACE)) begin
      leaf_mem[leaf_addr] <= symbol_i;
    end
    if (accept) begin
      leaf_rd_q <= leaf_mem[leaf_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_set || (out_valid_q && out_stall_i);
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + NAW'(1);
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            sym_q  <= symbol_i;
            node_q <= NAW'(LEAVES) + NAW'(position_i);
            old_q  <= '0;
            acc_q  <= '0;
            if (upd_ok && req_type_i == REQ_ADD) begin
              rep_q   <= 1'b0;
              state_q <= ST_URD;
            end else if (upd_ok && req_type_i == REQ_REPLACE) begin
              rep_q   <= 1'b1;
              state_q <= ST_LEAF;
            end else if (req_type_i == REQ_QUERY) begin
              if (32'(range_lo_i) < hi_c) begin
                a_q <= IW'(range_lo_i) + IW'(LEAVES);
                b_q <= IW'(hi_c) + IW'(LEAVES);
              end else begin
                a_q <= '0;
                b_q <= '0;
              end
              state_q <= ST_QTOP;
            end
          end
        end
        ST_LEAF: begin
          old_q   <= (32'(leaf_rd_q) < ALPHABET) ? leaf_rd_q : '0;
          state_q <= ST_URD;
        end
        ST_URD: state_q <= ST_UWR;
        ST_UWR: begin
          node_q <= node_q >> 1;
          state_q <= (node_q == NAW'(1)) ? ST_IDLE : ST_URD;
        end
        ST_QTOP: begin
          if (a_q < b_q) begin
            state_q <= ST_QA;
          end else if (out_free) begin
            mask_q  <= acc_q;
            state_q <= ST_IDLE;
          end
        end
        ST_QA: begin
          if (a_q[0]) begin
            a_q     <= a_q + IW'(1);
            state_q <= ST_QAW;
          end else begin
            state_q <= ST_QB;
          end
        end
        ST_QAW: begin
          acc_q   <= acc_q | alu_mask;
          state_q <= ST_QB;
        end
        ST_QB: begin
          if (b_q[0]) begin
            b_q     <= b_dec;
            state_q <= ST_QBW;
          end else begin
            state_q <= ST_QSH;
          end
        end
        ST_QBW: begin
          acc_q   <= acc_q | alu_mask;
          state_q <= ST_QSH;
        end
        ST_QSH: begin
          a_q     <= a_q >> 1;
          b_q     <= b_q >> 1;
          state_q <= ST_QTOP;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign present_mask_o = mask_q;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("transaction accepted during the clearing pass");
  a_no_root_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != ST_CLEAR) |-> (mem_waddr != '0))
    else $error("node update wrote past the root");
  a_query_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QB) |-> (a_q <= b_q))
    else $error("query bounds crossed");
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_QTOP))
    else $error("result raised outside a query");
`endif

endmodule

FILE: bench/rdst_checker.sv
// ----------------------------------------------------------------------------
// Range distinct-symbol tree checker
// Watches both channels of the block, keeps its own copy of the per-node
// symbol counts, predicts the presence mask of every accepted query and
// compares each delivered mask with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rdst_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [1:0]                   req_type_i,
  input  logic [rdst_pkg::POS_W-1:0]   position_i,
  input  logic [rdst_pkg::SYM_W-1:0]   symbol_i,
  input  logic [rdst_pkg::RANGE_W-1:0] range_lo_i,
  input  logic [rdst_pkg::RANGE_W-1:0] range_hi_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [rdst_pkg::MASK_W-1:0]  present_mask_i,
  output int                           fail_count_o,
  output int                           masks_pending_o,
  output int                           masks_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rdst_pkg::*;

  localparam int unsigned NLEAF = LEAVES_DEF;
  localparam int unsigned NSYM  = ALPHABET_DEF;

  logic [COUNT_W-1:0] sym_count [1:2*NLEAF-1][0:NSYM-1];
  logic [SYM_W-1:0]   held_sym  [0:NLEAF-1];
  logic [MASK_W-1:0]  mask_queue [$];

  initial begin
    fail_count_o    = 0;
    masks_checked_o = 0;
    masks_pending_o = 0;
    for (int n = 1; n < 2 * NLEAF; n++) begin
      for (int s = 0; s < NSYM; s++) sym_count[n][s] = '0;
    end
    for (int p = 0; p < NLEAF; p++) held_sym[p] = '0;
  end

  task automatic report_mismatch(input string what, input logic [MASK_W-1:0] want,
                                 input logic [MASK_W-1:0] got);
    $display("ERROR %0t: %s expected %07h got %07h", $realtime, what, want, got);
    fail_count_o++;
  endtask

  function automatic logic [MASK_W-1:0] node_presence(input int unsigned n);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int s = 0; s < NSYM; s++) if (sym_count[n][s] != 0) m[s] = 1'b1;
    return m;
  endfunction

  task automatic apply_update(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [SYM_W-1:0] sym);
    int unsigned n;
    int unsigned old;
    if (pos >= NLEAF || sym >= NSYM) return;
    old = held_sym[pos];
    if (old >= NSYM) old = 0;
    n = pos + NLEAF;
    while (n >= 1) begin
      if (kind == REQ_REPLACE && sym_count[n][old] != 0) sym_count[n][old]--;
      if (sym_count[n][sym] != COUNT_MAX) sym_count[n][sym]++;
      n = n >> 1;
    end
    held_sym[pos] = sym;
  endtask

  function automatic logic [MASK_W-1:0] range_presence(input int unsigned lo,
                                                       input int unsigned hi);
    logic [MASK_W-1:0] m;
    int unsigned a;
    int unsigned b;
    m = '0;
    if (hi > NLEAF) hi = NLEAF;
    if (lo < hi) begin
      a = lo + NLEAF;
      b = hi + NLEAF;
      while (a < b) begin
        if (a[0]) begin
          m |= node_presence(a);
          a++;
        end
        if (b[0]) begin
          b--;
          m |= node_presence(b);
        end
        a = a >> 1;
        b = b >> 1;
      end
    end
    return m;
  endfunction

  // Handshakes are sampled on the falling edge ahead of the rising edge that completes them.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        if (req_type_i == REQ_ADD || req_type_i == REQ_REPLACE) begin
          apply_update(req_type_i, position_i, symbol_i);
        end else if (req_type_i == REQ_QUERY) begin
          mask_queue.push_back(range_presence(range_lo_i, range_hi_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (mask_queue.size() == 0) begin
          report_mismatch("unexpected mask", '0, present_mask_i);
        end else begin
          logic [MASK_W-1:0] want;
          want = mask_queue.pop_front();
          masks_checked_o++;
          if (want !== present_mask_i) report_mismatch("present_mask", want, present_mask_i);
        end
      end
      masks_pending_o = mask_queue.size();
    end
  end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Range distinct-symbol tree testbench
// Drives add, replace and query transactions with random gaps and output
// stalls, including a long receiver hold-off and a burst of repeated adds
// at one position; the checker module predicts and compares every mask.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rdst_pkg::*;

  localparam int unsigned NLEAF     = LEAVES_DEF;
  localparam int          CYCLE_MAX = 3000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           req_type;
  logic [POS_W-1:0]     position;
  logic [SYM_W-1:0]     symbol;
  logic [RANGE_W-1:0]   range_lo;
  logic [RANGE_W-1:0]   range_hi;
  logic                 out_valid;
  logic                 out_stall;
  logic [MASK_W-1:0]    present_mask;
  int                   fail_count;
  int                   masks_pending;
  int                   masks_checked;
  int                   cycles;
  int                   sent;
  bit                   no_gaps;
  bit                   long_hold;
  bit                   written [0:NLEAF-1];

  range_distinct_symbol_tree uut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .position_i(position), .symbol_i(symbol),
    .range_lo_i(range_lo), .range_hi_i(range_hi), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .present_mask_o(present_mask)
  );

  rdst_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .req_type_i(req_type), .position_i(position), .symbol_i(symbol),
    .range_lo_i(range_lo), .range_hi_i(range_hi), .out_valid_i(out_valid),
    .out_stall_i(out_stall), .present_mask_i(present_mask),
    .fail_count_o(fail_count), .masks_pending_o(masks_pending),
    .masks_checked_o(masks_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_MAX) begin
        $display("timeout after %0d cycles", cycles);
        $display("range_distinct_symbol_tree: mismatch");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [1:0] kind, input int unsigned pos,
                              input int unsigned sym, input int unsigned lo,
                              input int unsigned hi);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    position <= pos[POS_W-1:0];
    symbol   <= sym[SYM_W-1:0];
    range_lo <= lo[RANGE_W-1:0];
    range_hi <= hi[RANGE_W-1:0];
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if ((kind == REQ_ADD || kind == REQ_REPLACE) && sym < ALPHABET_DEF) written[pos] = 1'b1;
    sent++;
  endtask

  function automatic int unsigned written_pos();
    int unsigned p;
    p = $urandom_range(0, NLEAF - 1);
    for (int k = 0; k < NLEAF; k++) begin
      if (written[(p + k) % NLEAF]) return (p + k) % NLEAF;
    end
    return 0;
  endfunction

  task automatic random_request();
    int          pick;
    int unsigned pos;
    int unsigned sym;
    int unsigned lo;
    int unsigned hi;
    pick = $urandom_range(0, 99);
    pos  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NLEAF - 1) : $urandom_range(0, 63);
    sym  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 25);
    lo   = $urandom_range(0, 2047);
    hi   = $urandom_range(0, 2047);
    if ($urandom_range(0, 3) != 0) begin
      lo = $urandom_range(0, NLEAF);
      hi = lo + $urandom_range(0, 80);
      if ($urandom_range(0, 4) == 0) hi = $urandom_range(0, NLEAF);
    end
    if (pick < 30) send_request(REQ_ADD, pos, sym, 0, 0);
    else if (pick < 50) send_request(REQ_REPLACE, written_pos(), sym, 0, 0);
    else if (pick < 95) send_request(REQ_QUERY, $urandom, $urandom, lo, hi);
    else send_request(REQ_RESERVED, $urandom, $urandom, lo, hi);
  endtask

  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      n = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (long_hold) begin
        n = 600;
        long_hold = 1'b0;
      end
      repeat (n) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    req_type  = REQ_ADD;
    position  = '0;
    symbol    = '0;
    range_lo  = '0;
    range_hi  = '0;
    sent      = 0;
    no_gaps   = 1'b0;
    long_hold = 1'b0;
    for (int p = 0; p < NLEAF; p++) written[p] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(REQ_QUERY, 0, 0, 0, NLEAF);
    send_request(REQ_ADD, 0, 0, 0, 0);
    send_request(REQ_ADD, NLEAF - 1, 25, 0, 0);
    send_request(REQ_ADD, 5, 31, 0, 0);
    send_request(REQ_ADD, 6, 26, 0, 0);
    send_request(REQ_ADD, 7, 3, 0, 0);
    send_request(REQ_ADD, 7, 9, 0, 0);
    send_request(REQ_QUERY, 0, 0, 7, 8);
    send_request(REQ_REPLACE, 7, 9, 0, 0);
    send_request(REQ_REPLACE, 7, 12, 0, 0);
    send_request(REQ_REPLACE, 0, 30, 0, 0);
    send_request(REQ_QUERY, 0, 0, 0, 8);
    send_request(REQ_QUERY, 0, 0, NLEAF - 1, 2047);
    send_request(REQ_QUERY, 0, 0, 9, 9);
    send_request(REQ_QUERY, 0, 0, 2047, 3);
    send_request(REQ_QUERY, 1023, 31, 1, NLEAF - 1);
    send_request(REQ_RESERVED, 7, 4, 0, NLEAF);
    send_request(REQ_QUERY, 0, 0, 0, 1);

    // Stack up repeated adds of one symbol at a single position.
    no_gaps = 1'b1;
    repeat (40) send_request(REQ_ADD, 300, 17, 0, 0);
    no_gaps = 1'b0;
    send_request(REQ_QUERY, 0, 0, 300, 301);
    send_request(REQ_REPLACE, 300, 18, 0, 0);
    send_request(REQ_QUERY, 0, 0, 0, NLEAF);

    for (int i = 0; i < 620; i++) begin
      if (i == 250) long_hold = 1'b1;
      if (i == 250) no_gaps = 1'b1;
      if (i == 300) no_gaps = 1'b0;
      if (i == 450) begin
        in_valid <= 1'b0;
        while (masks_pending != 0) @(posedge clk);
      end
      random_request();
    end
    in_valid <= 1'b0;

    while (masks_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d transactions, checked %0d presence masks, stacked repeated adds",
             sent, masks_checked);
    $display("covered empty, clamped and full ranges, ignored codes and a long output stall");
    if (fail_count == 0) begin
      $display("range_distinct_symbol_tree: match");
    end else begin
      $display("range_distinct_symbol_tree: mismatch");
    end
    $finish;
  end

endmodule
